[design/tbd_pkg.sv]
// Package for the thread block dispatcher: sizes, codes, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
package tbd_pkg;

   localparam int MaxBlocks   = 64;
   localparam int MaxNodes    = 1024;
   localparam int MaxResident = 16;
   localparam int EventCap    = 32;

   localparam int BlkW  = 6;
   localparam int NodeW = 10;
   localparam int CycW  = 48;
   localparam int CntW  = 11;
   localparam int TotW  = 5;
   localparam int LimW  = 5;
   localparam int LatW  = 16;
   localparam int FifoW = 7;
   localparam int EvW   = 6;

   localparam logic [CntW-1:0] CountMax = 11'd2047;

   localparam logic CSR_MAX_RESIDENT     = 1'b0;
   localparam logic CSR_DISPATCH_LATENCY = 1'b1;

   localparam logic EV_DISPATCH = 1'b0;
   localparam logic EV_RETIRE   = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_DONE  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_DONE_RD,
      ST_DONE_MAP,
      ST_DONE_WR,
      ST_START_WALK,
      ST_TICK_RD,
      ST_TICK_EXEC,
      ST_DRAIN_RD,
      ST_DRAIN_EXEC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic load_rd;
      logic load_wr;
      logic done_rd;
      logic done_map;
      logic done_wr;
      logic start_step;
      logic tick_rd;
      logic tick_step;
      logic drain_rd;
      logic drain_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic start_hit;
      logic room;
      logic tick_hit;
      logic drain_go;
      logic drain_wait;
      logic walk_last;
      logic emit_block;
      logic finish_block;
   } status_type;

endpackage

[design/tbd_ctrl.sv]
// Sequencer of the thread block dispatcher.
// Depends on tbd_pkg for the state type and the command/status structs.
module tbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_op,
   input  tbd_pkg::status_type status,
   output tbd_pkg::cmd_type    cmd,
   output logic                req_stall
);

   tbd_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff != tbd_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbd_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = tbd_pkg::ST_IDLE;
         end
         tbd_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (tbd_pkg::op_type'(req_op))
                  tbd_pkg::OP_LOAD:  state_in = tbd_pkg::ST_LOAD_RD;
                  tbd_pkg::OP_START: state_in = tbd_pkg::ST_START_WALK;
                  tbd_pkg::OP_DONE:  state_in = tbd_pkg::ST_DONE_RD;
                  tbd_pkg::OP_TICK:  state_in = tbd_pkg::ST_TICK_RD;
                  default:           state_in = tbd_pkg::ST_IDLE;
               endcase
            end
         end
         tbd_pkg::ST_LOAD_RD:  state_in = tbd_pkg::ST_LOAD_WR;
         tbd_pkg::ST_LOAD_WR:  state_in = tbd_pkg::ST_FINISH;
         tbd_pkg::ST_DONE_RD:  state_in = tbd_pkg::ST_DONE_MAP;
         tbd_pkg::ST_DONE_MAP: state_in = tbd_pkg::ST_DONE_WR;
         tbd_pkg::ST_DONE_WR:  state_in = tbd_pkg::ST_FINISH;
         tbd_pkg::ST_START_WALK: begin
            if (!(status.start_hit && status.room && status.emit_block) && status.walk_last)
               state_in = tbd_pkg::ST_FINISH;
         end
         tbd_pkg::ST_TICK_RD: state_in = tbd_pkg::ST_TICK_EXEC;
         tbd_pkg::ST_TICK_EXEC: begin
            if (!(status.tick_hit && status.emit_block)) begin
               state_in = status.walk_last ? tbd_pkg::ST_DRAIN_RD : tbd_pkg::ST_TICK_RD;
            end
         end
         tbd_pkg::ST_DRAIN_RD: begin
            state_in = status.drain_go ? tbd_pkg::ST_DRAIN_EXEC : tbd_pkg::ST_FINISH;
         end
         tbd_pkg::ST_DRAIN_EXEC: begin
            if (status.drain_wait) state_in = tbd_pkg::ST_FINISH;
            else if (!status.emit_block) state_in = tbd_pkg::ST_DRAIN_RD;
         end
         tbd_pkg::ST_FINISH: begin
            if (!status.finish_block) state_in = tbd_pkg::ST_IDLE;
         end
         default: state_in = tbd_pkg::ST_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.accept = accept;
      unique case (state_ff)
         tbd_pkg::ST_CLEAR:    cmd.clear_step = 1'b1;
         tbd_pkg::ST_IDLE:     ;
         tbd_pkg::ST_LOAD_RD:  cmd.load_rd = 1'b1;
         tbd_pkg::ST_LOAD_WR:  cmd.load_wr = 1'b1;
         tbd_pkg::ST_DONE_RD:  cmd.done_rd = 1'b1;
         tbd_pkg::ST_DONE_MAP: cmd.done_map = 1'b1;
         tbd_pkg::ST_DONE_WR:  cmd.done_wr = 1'b1;
         tbd_pkg::ST_START_WALK:
            cmd.start_step = !(status.start_hit && status.room && status.emit_block);
         tbd_pkg::ST_TICK_RD:  cmd.tick_rd = 1'b1;
         tbd_pkg::ST_TICK_EXEC:
            cmd.tick_step = !(status.tick_hit && status.emit_block);
         tbd_pkg::ST_DRAIN_RD: cmd.drain_rd = 1'b1;
         tbd_pkg::ST_DRAIN_EXEC:
            cmd.drain_step = !status.drain_wait && !status.emit_block;
         tbd_pkg::ST_FINISH:   cmd.finish = !status.finish_block;
         default: ;
      endcase
   end

endmodule

[design/tbd_datapath.sv]
// Datapath of the thread block dispatcher: node map, pending counts, block
// flags, wait and ready-time FIFOs, event holding and output register. Uses tbd_pkg.
module tbd_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [tbd_pkg::LatW-1:0]   csr_wdata,
   input  logic [1:0]                 req_op,
   input  logic [tbd_pkg::NodeW-1:0]  req_node_id,
   input  logic [tbd_pkg::BlkW-1:0]   req_block_id,
   input  logic [tbd_pkg::CycW-1:0]   req_now_cycle,
   input  tbd_pkg::cmd_type           cmd,
   output tbd_pkg::status_type        status,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic                       rsp_event_kind,
   output logic [tbd_pkg::BlkW-1:0]   rsp_event_block,
   output logic                       rsp_last
);

   logic [tbd_pkg::LimW-1:0] max_res_ff;
   logic [tbd_pkg::LatW-1:0] lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_res_ff <= tbd_pkg::LimW'(tbd_pkg::MaxResident);
         lat_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tbd_pkg::CSR_MAX_RESIDENT:     max_res_ff <= csr_wdata[tbd_pkg::LimW-1:0];
            tbd_pkg::CSR_DISPATCH_LATENCY: lat_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [tbd_pkg::LimW-1:0] limit;
   always_comb begin
      limit = max_res_ff;
      if (max_res_ff == '0) limit = tbd_pkg::LimW'(1);
      if (max_res_ff > tbd_pkg::LimW'(tbd_pkg::MaxResident))
         limit = tbd_pkg::LimW'(tbd_pkg::MaxResident);
   end

   // latched transaction
   logic [tbd_pkg::NodeW-1:0] node_ff;
   logic [tbd_pkg::BlkW-1:0]  blk_ff;
   logic [tbd_pkg::CycW-1:0]  now_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         node_ff <= req_node_id;
         blk_ff  <= req_block_id;
         now_ff  <= req_now_cycle;
      end
   end

   // clearing pass over the node map
   logic [tbd_pkg::NodeW-1:0] clr_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_idx_ff <= '0;
      else if (cmd.clear_step) clr_idx_ff <= clr_idx_ff + 1'b1;
   end

   logic [tbd_pkg::BlkW:0] map_mem [tbd_pkg::MaxNodes];
   logic [tbd_pkg::BlkW:0] map_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) map_mem[clr_idx_ff] <= '0;
      else if (cmd.load_wr) map_mem[node_ff] <= {1'b1, blk_ff};
      if (cmd.done_rd) map_q_ff <= map_mem[node_ff];
   end

   // walk index over block slots
   logic [tbd_pkg::BlkW-1:0] walk_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) walk_ff <= '0;
      else if (cmd.start_step || cmd.tick_step) walk_ff <= walk_ff + 1'b1;
   end

   // pending counts with per-entry valid bits
   logic [tbd_pkg::CntW-1:0]      cnt_mem [tbd_pkg::MaxBlocks];
   logic [tbd_pkg::MaxBlocks-1:0] cnt_vld_ff;
   logic [tbd_pkg::CntW-1:0]      cnt_q_ff;
   logic                          cnt_qv_ff;
   logic [tbd_pkg::BlkW-1:0]      cnt_raddr, cnt_waddr;
   logic [tbd_pkg::CntW-1:0]      cnt_val, cnt_wdata;
   logic                          cnt_re, cnt_we;

   assign cnt_val = cnt_qv_ff ? cnt_q_ff : '0;
   assign cnt_re  = cmd.load_rd || cmd.done_map || cmd.tick_rd;

   always_comb begin
      cnt_raddr = walk_ff;
      if (cmd.load_rd) cnt_raddr = blk_ff;
      else if (cmd.done_map) cnt_raddr = map_q_ff[tbd_pkg::BlkW-1:0];
      cnt_we    = 1'b0;
      cnt_waddr = blk_ff;
      cnt_wdata = (cnt_val == tbd_pkg::CountMax) ? cnt_val : cnt_val + 1'b1;
      if (cmd.load_wr) begin
         cnt_we = 1'b1;
      end else if (cmd.done_wr && map_q_ff[tbd_pkg::BlkW] && cnt_val != '0) begin
         cnt_we    = 1'b1;
         cnt_waddr = map_q_ff[tbd_pkg::BlkW-1:0];
         cnt_wdata = cnt_val - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (cnt_re) begin
         cnt_q_ff  <= cnt_mem[cnt_raddr];
         cnt_qv_ff <= cnt_vld_ff[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_vld_ff <= '0;
      else if (cnt_we) cnt_vld_ff[cnt_waddr] <= 1'b1;
   end

   // block flags, residency and FIFOs
   logic [tbd_pkg::MaxBlocks-1:0] present_ff, resident_ff;
   logic [tbd_pkg::TotW-1:0]      total_ff;
   logic [tbd_pkg::FifoW-1:0]     wcount_ff, rcount_ff;
   logic [tbd_pkg::BlkW-1:0]      whead_ff, rhead_ff;
   logic [tbd_pkg::BlkW-1:0]      wait_mem [tbd_pkg::MaxBlocks];
   logic [tbd_pkg::CycW-1:0]      ready_mem [tbd_pkg::MaxBlocks];
   logic [tbd_pkg::BlkW-1:0]      wait_q_ff;
   logic [tbd_pkg::CycW-1:0]      ready_q_ff;
   logic [tbd_pkg::CycW:0]        ready_sum;
   logic [tbd_pkg::CycW-1:0]      ready_time;
   logic                          start_push, retire_push, fifo_full_w, fifo_full_r;

   assign ready_sum  = {1'b0, now_ff} + {{(tbd_pkg::CycW+1-tbd_pkg::LatW){1'b0}}, lat_ff};
   assign ready_time = ready_sum[tbd_pkg::CycW] ? '1 : ready_sum[tbd_pkg::CycW-1:0];
   assign fifo_full_w = (wcount_ff == tbd_pkg::FifoW'(tbd_pkg::MaxBlocks));
   assign fifo_full_r = (rcount_ff == tbd_pkg::FifoW'(tbd_pkg::MaxBlocks));

   assign status.start_hit  = present_ff[walk_ff] && !resident_ff[walk_ff];
   assign status.room       = ({1'b0, total_ff} < {1'b0, limit});
   assign status.tick_hit   = resident_ff[walk_ff] && (cnt_val == '0);
   assign status.drain_go   = status.room && (wcount_ff != '0);
   assign status.drain_wait = (rcount_ff != '0) && (now_ff < ready_q_ff);
   assign status.walk_last  = (walk_ff == tbd_pkg::BlkW'(tbd_pkg::MaxBlocks - 1));
   assign status.clear_last = (clr_idx_ff == tbd_pkg::NodeW'(tbd_pkg::MaxNodes - 1));

   assign start_push  = cmd.start_step && status.start_hit && !status.room && !fifo_full_w;
   assign retire_push = cmd.tick_step && status.tick_hit && !fifo_full_r;

   always_ff @(posedge clock) begin
      if (start_push)
         wait_mem[whead_ff + wcount_ff[tbd_pkg::BlkW-1:0]] <= walk_ff;
      if (retire_push)
         ready_mem[rhead_ff + rcount_ff[tbd_pkg::BlkW-1:0]] <= ready_time;
      if (cmd.drain_rd) begin
         wait_q_ff  <= wait_mem[whead_ff];
         ready_q_ff <= ready_mem[rhead_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         resident_ff <= '0;
         total_ff    <= '0;
         wcount_ff   <= '0;
         rcount_ff   <= '0;
         whead_ff    <= '0;
         rhead_ff    <= '0;
      end else begin
         if (cmd.accept && tbd_pkg::op_type'(req_op) == tbd_pkg::OP_START) begin
            wcount_ff <= '0;
            rcount_ff <= '0;
            whead_ff  <= '0;
            rhead_ff  <= '0;
         end
         if (cmd.load_wr) present_ff[blk_ff] <= 1'b1;
         if (cmd.start_step && status.start_hit && status.room) begin
            resident_ff[walk_ff] <= 1'b1;
            total_ff <= total_ff + 1'b1;
         end
         if (start_push) wcount_ff <= wcount_ff + 1'b1;
         if (cmd.tick_step && status.tick_hit) begin
            resident_ff[walk_ff] <= 1'b0;
            present_ff[walk_ff]  <= 1'b0;
            if (total_ff != '0) total_ff <= total_ff - 1'b1;
         end
         if (retire_push) rcount_ff <= rcount_ff + 1'b1;
         if (cmd.drain_step) begin
            if (rcount_ff != '0) begin
               rhead_ff  <= rhead_ff + 1'b1;
               rcount_ff <= rcount_ff - 1'b1;
            end
            whead_ff  <= whead_ff + 1'b1;
            wcount_ff <= wcount_ff - 1'b1;
            resident_ff[wait_q_ff] <= 1'b1;
            total_ff <= total_ff + 1'b1;
         end
      end
   end

   // event holding: the newest event waits here until the next one or the
   // end of the transaction decides its last flag
   logic                     emit_req, emit_kind, emit_take, ev_full, out_free, push;
   logic [tbd_pkg::BlkW-1:0] emit_blk;
   logic                     held_vld_ff, held_kind_ff;
   logic [tbd_pkg::BlkW-1:0] held_blk_ff;
   logic [tbd_pkg::EvW-1:0]  ev_cnt_ff;
   logic                     rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [tbd_pkg::BlkW-1:0] rsp_blk_ff;

   always_comb begin
      emit_req  = 1'b0;
      emit_kind = tbd_pkg::EV_DISPATCH;
      emit_blk  = walk_ff;
      if (cmd.start_step && status.start_hit && status.room) begin
         emit_req = 1'b1;
      end else if (cmd.tick_step && status.tick_hit) begin
         emit_req  = 1'b1;
         emit_kind = tbd_pkg::EV_RETIRE;
      end else if (cmd.drain_step) begin
         emit_req = 1'b1;
         emit_blk = wait_q_ff;
      end
   end

   assign ev_full   = (ev_cnt_ff == tbd_pkg::EvW'(tbd_pkg::EventCap));
   assign emit_take = emit_req && !ev_full;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push      = held_vld_ff && ((emit_take) || cmd.finish);

   assign status.emit_block   = held_vld_ff && !ev_full && !out_free;
   assign status.finish_block = held_vld_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff  <= 1'b0;
         ev_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) ev_cnt_ff <= '0;
         else if (emit_take) ev_cnt_ff <= ev_cnt_ff + 1'b1;
         if (emit_take) held_vld_ff <= 1'b1;
         else if (cmd.finish) held_vld_ff <= 1'b0;
         if (push) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take) begin
         held_kind_ff <= emit_kind;
         held_blk_ff  <= emit_blk;
      end
      if (push) begin
         rsp_kind_ff <= held_kind_ff;
         rsp_blk_ff  <= held_blk_ff;
         rsp_last_ff <= cmd.finish;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_block = rsp_blk_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[design/thread_block_dispatcher.sv]
// Top level of the thread block dispatcher.
// Depends on tbd_pkg, tbd_ctrl and tbd_datapath.

// Thread block dispatcher. One transaction at a time is taken on the req_
// channel (op, node_id, block_id, now_cycle) and its dispatch and retire
// events leave on the rsp_ channel, up to 32 per transaction, with rsp_last
// on the final one; a transaction with no events produces nothing. After
// reset the node map is cleared one entry a cycle, with req_stall high for
// the whole pass; csr_ writes are taken during that pass. A load reads
// the pending count, then writes it; a node done reads the node map, then
// the pending count, then writes it; a start walks the block slots; a tick
// walks them too (pending count memory read, then update), then dispatches
// queued blocks (wait FIFO read, then dispatch). An event that must move
// into a stalled output register holds the work back. The output register
// lets the next transaction be accepted while the final event still waits.
module thread_block_dispatcher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [tbd_pkg::LatW-1:0]   csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic [tbd_pkg::NodeW-1:0]  req_node_id,
   input  logic [tbd_pkg::BlkW-1:0]   req_block_id,
   input  logic [tbd_pkg::CycW-1:0]   req_now_cycle,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_kind,
   output logic [tbd_pkg::BlkW-1:0]   rsp_event_block,
   output logic                       rsp_last
);

   tbd_pkg::cmd_type    cmd;
   tbd_pkg::status_type status;

   // sequence the work of each transaction
   tbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // hold all block state and drive the result channel
   tbd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_op          (req_op),
      .req_node_id     (req_node_id),
      .req_block_id    (req_block_id),
      .req_now_cycle   (req_now_cycle),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_block (rsp_event_block),
      .rsp_last        (rsp_last)
   );

endmodule

[design/tbd_checker.sv]
// Port-level checks for the thread block dispatcher, bound to the top level.
// Depends on thread_block_dispatcher ports only.
module tbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_event_kind,
   input logic [5:0] rsp_event_block,
   input logic       rsp_last
);

   // clearing pass and empty output right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("block not quiet after reset");

   // one transaction at a time: stall right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         ($stable(rsp_event_kind) && $stable(rsp_event_block) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind thread_block_dispatcher tbd_checker u_tbd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_event_block (rsp_event_block),
   .rsp_last        (rsp_last)
);
